// ----- rtl/jls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_pkg - shared types and constants of the Jacobi stencil sweep core
// Word layouts of both channels, line buffer entries, register indexes.
// ----------------------------------------------------------------------------
package jls_pkg;

	// point value width, Q8.16
	localparam int VALUE_BITS      = 24;
	localparam int SUM_BITS        = VALUE_BITS + 2;

	// default grid limits
	localparam int MAX_WIDTH_DEF   = 256;
	localparam int MAX_HEIGHT_DEF  = 1024;

	// configuration port
	localparam int WIDTH_REG_BITS  = 9;
	localparam int HEIGHT_REG_BITS = 11;
	localparam int CFG_DATA_BITS   = 11;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int WIDTH_RESET     = 256;
	localparam int HEIGHT_RESET    = 256;

	// result position fields
	localparam int ROW_IDX_BITS    = 10;
	localparam int COL_IDX_BITS    = 8;

	// output queue
	localparam int OUT_DEPTH       = 4;
	localparam int OUT_PTR_BITS    = 2;
	localparam int OUT_CNT_BITS    = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] point_value;
		logic                         hold;
	} pt_word_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] new_value;
		logic [ROW_IDX_BITS-1:0]      row_index;
		logic [COL_IDX_BITS-1:0]      col_index;
		logic                         frame_end;
	} res_word_t;

	// one line buffer entry: value plus hold flag
	typedef struct packed {
		logic                         hold;
		logic signed [VALUE_BITS-1:0] value;
	} line_entry_t;

	// up to two result words pushed per point
	typedef struct packed {
		logic      a_valid;
		res_word_t a_word;
		logic      b_valid;
		res_word_t b_word;
	} res_push_t;

endpackage

// ----- rtl/jls_line_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_line_buf - upper and centre row buffers
// Two synchronous memories with registered reads. The centre row has two read
// ports (column c and c+1); the upper row one. Both written at one column.
// ----------------------------------------------------------------------------
module jls_line_buf #(
	parameter int MAX_WIDTH = jls_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
	input  jls_pkg::line_entry_t         wr_upper,
	input  jls_pkg::line_entry_t         wr_centre,
	output jls_pkg::line_entry_t         up_q,
	output jls_pkg::line_entry_t         cc_q,
	output jls_pkg::line_entry_t         cn_q
);
	import jls_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	line_entry_t upper_mem  [MAX_WIDTH];
	line_entry_t centre_mem [MAX_WIDTH];
	logic [AW-1:0] col_next;

	// right neighbour column, wraps at the end of the buffer
	assign col_next = (rd_col == AW'(MAX_WIDTH - 1)) ? '0 : rd_col + AW'(1);

	// write side: row shift for the current column
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_col]  <= wr_upper;
			centre_mem[wr_col] <= wr_centre;
		end
	end

	// read side: registered data, held while no new word is read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_q <= upper_mem[rd_col];
			cc_q <= centre_mem[rd_col];
			cn_q <= centre_mem[col_next];
		end
	end

endmodule

// ----- rtl/jls_out_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_out_fifo - result queue
// Small queue taking up to two result words per cycle, one out per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module jls_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  jls_pkg::res_push_t push,
	output logic               room2,
	output logic               res_valid,
	input  logic               res_ready,
	output jls_pkg::res_word_t res_word
);
	import jls_pkg::*;

	res_word_t               fifo_q [OUT_DEPTH];
	logic [OUT_PTR_BITS-1:0] wr_ptr_q;
	logic [OUT_PTR_BITS-1:0] rd_ptr_q;
	logic [OUT_CNT_BITS-1:0] count_q;
	logic [OUT_CNT_BITS-1:0] n_push;
	logic                    pop;

	assign pop       = res_valid && res_ready;
	assign n_push    = OUT_CNT_BITS'(push.a_valid) + OUT_CNT_BITS'(push.b_valid);
	assign room2     = (count_q <= OUT_CNT_BITS'(OUT_DEPTH - 2));
	assign res_valid = (count_q != '0);
	assign res_word  = fifo_q[rd_ptr_q];

	// storage; second word lands after the first
	always_ff @(posedge clk) begin
		if (push.a_valid) begin
			fifo_q[wr_ptr_q] <= push.a_word;
		end
		if (push.b_valid) begin
			fifo_q[wr_ptr_q + OUT_PTR_BITS'(1)] <= push.b_word;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_BITS'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_BITS'(1);
			end
			count_q <= count_q + n_push - OUT_CNT_BITS'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUT_CNT_BITS'(OUT_DEPTH))
		else $error("result queue overfilled");

	a_b_needs_a: assert property (@(posedge clk) disable iff (!arst_n)
		push.b_valid |-> push.a_valid)
		else $error("border word pushed without stencil word");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.a_valid |-> room2)
		else $error("push without room for two words");

endmodule

// ----- rtl/jacobi_laplace_stencil_sweep_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_laplace_stencil_sweep_core - one Jacobi sweep, 5-point stencil
// Raster stream of grid points in, updated points with row/column out.
//
//   channel   signals                         word
//   --------  ------------------------------  ------------------------------
//   point in  pt_valid / pt_ready / pt_word   point_value, hold
//   result    res_valid / res_ready / res_word new_value, row, col, frame_end
//   config    cfg_we / cfg_index / cfg_data   grid_width, grid_height
//
// One point per cycle while the result queue has room: a point is read from
// the line buffers when it is taken and written back when it leaves stage 1,
// so a new point can enter every cycle. Points of the last row give two
// results; the one-word-per-cycle result port then sets the pace. A result
// word passes through the stage 1 register and the result queue before it
// shows on the result port. No clearing pass after reset; a result stall
// lets the result queue reach three or four words and then holds pt_ready low.
// ----------------------------------------------------------------------------
module jacobi_laplace_stencil_sweep_core #(
	parameter int MAX_WIDTH  = jls_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = jls_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [jls_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [jls_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 pt_valid,
	output logic                                 pt_ready,
	input  jls_pkg::pt_word_t                    pt_word,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output jls_pkg::res_word_t                   res_word
);
	import jls_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	function automatic logic [WW-1:0] clamp_w(input logic [WIDTH_REG_BITS-1:0] v);
		int x;
		x = int'(v);
		if (x < 3) x = 3;
		if (x > MAX_WIDTH) x = MAX_WIDTH;
		return WW'(x);
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [HEIGHT_REG_BITS-1:0] v);
		int x;
		x = int'(v);
		if (x < 3) x = 3;
		if (x > MAX_HEIGHT) x = MAX_HEIGHT;
		return HW'(x);
	endfunction

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_e;
	logic [RW-1:0] row_e;
	logic          col_last;
	logic          row_last;
	logic          cfg_hit;
	logic          pt_acc;
	logic          s1_fire;
	logic          room2;

	// stage 1: point waiting for its line buffer data
	logic                         valid_s1;
	logic signed [VALUE_BITS-1:0] val_s1;
	logic                         hold_s1;
	logic [CW-1:0]                col_s1;
	logic [RW-1:0]                row_s1;
	logic                         r_ge1_s1;
	logic                         r_is1_s1;
	logic                         c_is0_s1;
	logic                         c_last_s1;
	logic                         r_last_s1;

	line_entry_t lb_up_q;
	line_entry_t lb_cc_q;
	line_entry_t lb_cn_q;
	line_entry_t left_q;
	line_entry_t centre_wr;

	logic signed [SUM_BITS-1:0]   sum;
	logic signed [VALUE_BITS-1:0] stencil_val;
	logic signed [VALUE_BITS-1:0] upd_val;
	logic                         fixed_pt;
	res_push_t                    push;

	// register decode
	always_comb begin
		unique case (cfg_index)
			REG_GRID_WIDTH,
			REG_GRID_HEIGHT: cfg_hit = cfg_we;
			default:         cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= clamp_w(WIDTH_REG_BITS'(WIDTH_RESET));
			height_q <= clamp_h(HEIGHT_REG_BITS'(HEIGHT_RESET));
		end else if (cfg_we) begin
			if (cfg_index == REG_GRID_WIDTH) begin
				width_q <= clamp_w(cfg_data[WIDTH_REG_BITS-1:0]);
			end
			if (cfg_index == REG_GRID_HEIGHT) begin
				height_q <= clamp_h(cfg_data[HEIGHT_REG_BITS-1:0]);
			end
		end
	end

	// raster position of the incoming point
	assign col_e    = (WW'(col_q) >= width_q)  ? '0 : col_q;
	assign row_e    = (HW'(row_q) >= height_q) ? '0 : row_q;
	assign col_last = (WW'(col_e) == width_q - WW'(1));
	assign row_last = (HW'(row_e) == height_q - HW'(1));

	assign s1_fire  = valid_s1 && room2;
	assign pt_ready = !valid_s1 || s1_fire;
	assign pt_acc   = pt_valid && pt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pt_acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_e + RW'(1);
			end else begin
				col_q <= col_e + CW'(1);
				row_q <= row_e;
			end
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pt_ready) begin
			valid_s1 <= pt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pt_acc) begin
			val_s1    <= pt_word.point_value;
			hold_s1   <= pt_word.hold;
			col_s1    <= col_e;
			row_s1    <= row_e;
			r_ge1_s1  <= (row_e != '0);
			r_is1_s1  <= (row_e == RW'(1));
			c_is0_s1  <= (col_e == '0);
			c_last_s1 <= col_last;
			r_last_s1 <= row_last;
		end
	end

	assign centre_wr.hold  = hold_s1;
	assign centre_wr.value = val_s1;

	jls_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk       (clk),
		.rd_en     (pt_acc),
		.rd_col    (col_e),
		.wr_en     (s1_fire),
		.wr_col    (col_s1),
		.wr_upper  (lb_cc_q),
		.wr_centre (centre_wr),
		.up_q      (lb_up_q),
		.cc_q      (lb_cc_q),
		.cn_q      (lb_cn_q)
	);

	// left neighbour: centre entry of the previous column
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			left_q <= lb_cc_q;
		end
	end

	// four-neighbour sum, arithmetic shift by two
	assign sum = SUM_BITS'(lb_up_q.value) + SUM_BITS'(val_s1)
	           + SUM_BITS'(left_q.value)  + SUM_BITS'(lb_cn_q.value);
	assign stencil_val = sum[SUM_BITS-1:2];

	// border rows/columns and plates pass through
	assign fixed_pt = r_is1_s1 || c_is0_s1 || c_last_s1 || lb_cc_q.hold;
	assign upd_val  = fixed_pt ? lb_cc_q.value : stencil_val;

	// result words: point above, then last-row border point
	always_comb begin
		push.a_valid          = s1_fire && r_ge1_s1;
		push.a_word.new_value = upd_val;
		push.a_word.row_index = ROW_IDX_BITS'(row_s1 - RW'(1));
		push.a_word.col_index = COL_IDX_BITS'(col_s1);
		push.a_word.frame_end = 1'b0;
		push.b_valid          = s1_fire && r_ge1_s1 && r_last_s1;
		push.b_word.new_value = val_s1;
		push.b_word.row_index = ROW_IDX_BITS'(row_s1);
		push.b_word.col_index = COL_IDX_BITS'(col_s1);
		push.b_word.frame_end = c_last_s1;
	end

	jls_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1 && $stable(col_s1) && $stable(row_s1))
		else $error("stage 1 point lost while stalled");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		pt_acc && !cfg_hit && !col_last |=> col_q == $past(col_e) + CW'(1))
		else $error("column counter did not advance");

	a_acc_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pt_acc |=> valid_s1)
		else $error("accepted point missing from stage 1");

endmodule

// ----- tb/sv/jacobi_laplace_stencil_sweep_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_laplace_stencil_sweep_core_tb - self-checking bench of the sweep core
// Streams raster grids through the core under random source bursts and sink
// stalls. A local stencil model with its own line buffers computes each
// updated point, and every result word is checked field by field.
// ----------------------------------------------------------------------------
module jacobi_laplace_stencil_sweep_core_tb;
	import jls_pkg::*;

	localparam int CYCLE_LIMIT     = 300000;
	localparam int LATENCY_CYCLES  = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int REPORT_LIMIT    = 10;
	localparam int GRID_MIN        = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

	localparam logic signed [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// sink stall patterns
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]    cfg_data  = '0;
	logic                        pt_valid  = 1'b0;
	logic                        pt_ready;
	pt_word_t                    pt_word   = '0;
	logic                        res_valid;
	logic                        res_ready = 1'b0;
	res_word_t                   res_word;

	// points waiting to be driven, results waiting to arrive
	pt_word_t  raster_q[$];
	res_word_t sweep_due[$];

	// local copy of the core's state
	line_entry_t                 upper_rows [MAX_WIDTH_DEF];
	line_entry_t                 centre_rows[MAX_WIDTH_DEF];
	line_entry_t                 left_entry = '0;
	int                          col_pos    = 0;
	int                          row_pos    = 0;
	logic [WIDTH_REG_BITS-1:0]   width_reg  = WIDTH_REG_BITS'(WIDTH_RESET);
	logic [HEIGHT_REG_BITS-1:0]  height_reg = HEIGHT_REG_BITS'(HEIGHT_RESET);

	bit       pt_fire        = 1'b0;
	int       queued_count   = 0;
	int       taken_count    = 0;
	int       checked_count  = 0;
	int       mismatch_count = 0;
	int       reg_writes     = 0;
	int       burst_left     = 0;
	int       gap_left       = 0;
	int       hold_off_asks  = 0;
	int       hold_off_seen  = 0;
	int       hold_off_left  = 0;
	int       seg_left       = 0;
	rx_mode_t rx_mode        = RX_OPEN;

	jacobi_laplace_stencil_sweep_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pt_valid  (pt_valid),
		.pt_ready  (pt_ready),
		.pt_word   (pt_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// effective grid size after clamping
	function automatic int grid_cols();
		if (width_reg < GRID_MIN) return GRID_MIN;
		if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return int'(width_reg);
	endfunction

	function automatic int grid_rows();
		if (height_reg < GRID_MIN) return GRID_MIN;
		if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
		return int'(height_reg);
	endfunction

	// one raster point into the stencil: queue the results it releases
	task automatic sweep_point(input pt_word_t w);
		int                          gw;
		int                          gh;
		int                          c;
		int                          r;
		line_entry_t                 mid;
		line_entry_t                 cur;
		logic signed [SUM_BITS-1:0]  s_up;
		logic signed [SUM_BITS-1:0]  s_dn;
		logic signed [SUM_BITS-1:0]  s_lf;
		logic signed [SUM_BITS-1:0]  s_rt;
		logic signed [SUM_BITS-1:0]  sum;
		res_word_t                   rw;
		gw = grid_cols();
		gh = grid_rows();
		c  = (col_pos >= gw) ? 0 : col_pos;
		r  = (row_pos >= gh) ? 0 : row_pos;
		mid       = centre_rows[c];
		cur.hold  = w.hold;
		cur.value = w.point_value;
		if (r >= 1) begin
			rw.row_index = ROW_IDX_BITS'(r - 1);
			rw.col_index = COL_IDX_BITS'(c);
			rw.frame_end = 1'b0;
			// border rows/columns and plates pass through
			if (r == 1 || c == 0 || c == gw - 1 || mid.hold) begin
				rw.new_value = mid.value;
			end else begin
				s_up = upper_rows[c].value;
				s_dn = w.point_value;
				s_lf = left_entry.value;
				s_rt = centre_rows[c + 1].value;
				sum  = s_up + s_dn + s_lf + s_rt;
				// divide by four, floor
				rw.new_value = sum[SUM_BITS-1:2];
			end
			sweep_due.push_back(rw);
			// last row: the border point itself follows
			if (r == gh - 1) begin
				rw.new_value = w.point_value;
				rw.row_index = ROW_IDX_BITS'(r);
				rw.col_index = COL_IDX_BITS'(c);
				rw.frame_end = (c == gw - 1);
				sweep_due.push_back(rw);
			end
		end
		left_entry     = mid;
		upper_rows[c]  = mid;
		centre_rows[c] = cur;
		c++;
		if (c >= gw) begin
			c = 0;
			r++;
			if (r >= gh) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	// register write, mirrored into the local copy
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(data);
		case (idx)
			REG_GRID_WIDTH: begin
				width_reg = WIDTH_REG_BITS'(data);
				col_pos   = 0;
				row_pos   = 0;
			end
			REG_GRID_HEIGHT: begin
				height_reg = HEIGHT_REG_BITS'(data);
				col_pos    = 0;
				row_pos    = 0;
			end
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_point(input logic signed [VALUE_BITS-1:0] v, input logic h);
		pt_word_t w;
		w.point_value = v;
		w.hold        = h;
		raster_q.push_back(w);
		queued_count++;
	endtask

	function automatic logic signed [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(0, 9))
			0:       return V_MAX;
			1:       return V_MIN;
			2:       return VALUE_BITS'($signed($urandom_range(0, 32)) - 16);
			3:       return V_MAX - VALUE_BITS'($urandom_range(0, 3));
			4:       return V_MIN + VALUE_BITS'($urandom_range(0, 3));
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	// pushed at a rising edge so the driver sees a settled queue
	task automatic queue_random_points(input int n);
		@(posedge clk);
		repeat (n) queue_point(rand_value(), $urandom_range(0, 3) == 0);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (taken_count != queued_count || sweep_due.size() != 0) @(negedge clk);
	endtask

	// idle before a register write: drained, then the pipeline tail
	task automatic wait_idle();
		wait_drained();
		repeat (LATENCY_CYCLES) @(negedge clk);
	endtask

	// point source: bursts with random gaps
	always @(negedge clk) begin : point_driver
		if (!pt_valid || pt_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				pt_valid <= 1'b0;
			end else if (raster_q.size() == 0) begin
				pt_valid <= 1'b0;
			end else begin
				pt_word  <= raster_q.pop_front();
				pt_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// result sink: stall pattern changes per segment, long hold-off on request
	always @(negedge clk) begin : result_sink
		if (hold_off_asks != hold_off_seen) begin
			hold_off_seen = hold_off_asks;
			hold_off_left = HOLD_OFF_CYCLES;
		end
		if (seg_left == 0) begin
			seg_left = $urandom_range(20, 120);
			rx_mode  = rx_mode_t'($urandom_range(0, 3));
		end else begin
			seg_left--;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			res_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:   res_ready <= 1'b1;
				RX_COIN:   res_ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
				default:   res_ready <= ~res_ready;
			endcase
		end
	end

	// accepted points feed the model; accepted results are checked
	always @(posedge clk) begin : word_monitor
		res_word_t want;
		pt_fire = arst_n && pt_valid && pt_ready;
		if (pt_fire) begin
			sweep_point(pt_word);
			taken_count++;
		end
		if (arst_n && res_valid && res_ready) begin
			checked_count++;
			if (sweep_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: value %0d row %0d col %0d end %0b",
						res_word.new_value, res_word.row_index, res_word.col_index,
						res_word.frame_end);
			end else begin
				want = sweep_due.pop_front();
				if (want.new_value !== res_word.new_value ||
					want.row_index !== res_word.row_index ||
					want.col_index !== res_word.col_index ||
					want.frame_end !== res_word.frame_end) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch: exp %0d r%0d c%0d e%0b, got %0d r%0d c%0d e%0b",
							want.new_value, want.row_index, want.col_index,
							want.frame_end, res_word.new_value, res_word.row_index,
							res_word.col_index, res_word.frame_end);
				end
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("cycle limit of %0d reached, %0d results outstanding", CYCLE_LIMIT,
			sweep_due.size());
		$display("** jacobi_laplace_stencil_sweep_core: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int w_raw;
		int h_raw;
		int frames;
		for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
			upper_rows[i]  = '0;
			centre_rows[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry, part of row 0 only; a write must restart the raster
		queue_random_points(20);
		wait_idle();

		// 4x3 grid: interior at full scale, plate next to it, frame end
		write_reg(REG_GRID_WIDTH, 4);
		write_reg(REG_GRID_HEIGHT, 1);
		@(posedge clk);
		queue_point(V_MIN, 1'b0);  queue_point(V_MAX, 1'b0);
		queue_point(0, 1'b0);      queue_point(-1, 1'b1);
		queue_point(V_MAX, 1'b0);  queue_point(0, 1'b0);
		queue_point(V_MAX, 1'b1);  queue_point(V_MIN, 1'b0);
		queue_point(V_MIN, 1'b1);  queue_point(V_MAX, 1'b0);
		queue_point(-1, 1'b0);     queue_point(1, 1'b1);
		wait_idle();

		// 3x3 grid from undersized registers; floor on a negative sum;
		// spare indexes written mid-frame must not restart the raster
		write_reg(REG_GRID_WIDTH, 2);
		write_reg(REG_GRID_HEIGHT, 0);
		@(posedge clk);
		queue_point(1, 1'b1);      queue_point(V_MIN, 1'b0);  queue_point(V_MAX, 1'b0);
		wait_idle();
		write_reg(REG_SPARE_2, {CFG_DATA_BITS{1'b1}});
		write_reg(REG_SPARE_3, {CFG_DATA_BITS{1'b1}});
		@(posedge clk);
		queue_point(V_MIN, 1'b0);  queue_point(V_MAX, 1'b0);  queue_point(V_MIN, 1'b0);
		queue_point(0, 1'b0);      queue_point(V_MIN + 1, 1'b0); queue_point(0, 1'b1);
		wait_idle();

		// full-width rows, oversized width register; the source pauses
		// mid-frame until drained, then a long sink hold-off fills the core
		write_reg(REG_GRID_WIDTH, 511);
		write_reg(REG_GRID_HEIGHT, 3);
		queue_random_points(260);
		wait_drained();
		hold_off_asks++;
		queue_random_points(140);
		wait_idle();

		// small grids, one or two back-to-back frames each
		for (int s = 0; s < 5; s++) begin
			w_raw  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
			h_raw  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
			write_reg(REG_GRID_WIDTH, w_raw);
			write_reg(REG_GRID_HEIGHT, h_raw);
			frames = $urandom_range(1, 2);
			queue_random_points(frames * grid_cols() * grid_rows());
			wait_idle();
		end

		// tall grids, partial frames only
		write_reg(REG_GRID_WIDTH, 3);
		write_reg(REG_GRID_HEIGHT, 2047);
		queue_random_points(36);
		wait_idle();
		write_reg(REG_GRID_WIDTH, 256);
		write_reg(REG_GRID_HEIGHT, 1024);
		queue_random_points(20);
		wait_idle();

		// minimum grid, two frames, second one under a hold-off
		write_reg(REG_GRID_WIDTH, 3);
		write_reg(REG_GRID_HEIGHT, 3);
		queue_random_points(9);
		hold_off_asks++;
		queue_random_points(9);

		wait_drained();
		repeat (4 * LATENCY_CYCLES) @(negedge clk);
		$display("%0d points in, %0d results checked, %0d register writes", taken_count,
			checked_count, reg_writes);
		$display("grids from clamped 3x3 up to 256 wide and 1024 tall, plates and stalls");
		if (mismatch_count == 0 && sweep_due.size() == 0) begin
			$display("** jacobi_laplace_stencil_sweep_core: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count, sweep_due.size());
			$display("** jacobi_laplace_stencil_sweep_core: FAILED **");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/jls_pkg.sv
rtl/jls_line_buf.sv
rtl/jls_out_fifo.sv
rtl/jacobi_laplace_stencil_sweep_core.sv
tb/sv/jacobi_laplace_stencil_sweep_core_tb.sv
